// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define LCDX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LCDX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lcdx_pkg.sv
// Shared types, constants and character helpers for the LCD expander encoder.
`timescale 1ns / 1ps

package lcdx_pkg;

  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 16;
  localparam int COL_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int CHARS_MAX = 6;
  localparam int CHARS_W   = CHAR_W * CHARS_MAX;
  localparam int COUNT_W   = 3;
  localparam int DIGITS    = 5;
  localparam int BCD_W     = 4 * DIGITS;
  localparam int BITCNT_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CHAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEX8   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEX16  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC8   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEC16  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd5;

  // Expander control bits: backlight bit3, enable bit2, RS bit0
  localparam logic [7:0] BYTE_DATA_IDLE   = 8'b0000_1001;
  localparam logic [7:0] BYTE_DATA_STROBE = 8'b0000_1101;
  localparam logic [7:0] BYTE_CMD_IDLE    = 8'b0000_1000;
  localparam logic [7:0] BYTE_CMD_STROBE  = 8'b0000_1100;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] HEX_ALPHA  = 8'h37;

  // Enable strobe phases of one nibble
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_PULSE = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  typedef struct packed {
    logic [CHARS_W-1:0] chars;   // first character in the top byte
    logic [COUNT_W-1:0] count;
    logic               rs;
  } lcdx_load_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, d};
    return (d > 4'd9) ? ext + HEX_ALPHA : ext + CHAR_ZERO;
  endfunction

  function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] d);
    return CHAR_ZERO | {4'b0000, d};
  endfunction

endpackage

// File: sv/lcd_number_to_expander_bytes_top.sv
// Top level of the LCD command to expander byte encoder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  command  | cmd_valid, cmd_stall  | cmd, value, line, column
//  bytes    | byte_valid, byte_stall| expander_byte, last
//
// One command at a time. A command of N characters gives 6*N bytes, one per
// cycle while byte_stall is low, and no new command is accepted while it is
// in progress. Decimal commands first run the bit-serial BCD converter.
// Codes 6 and 7 are accepted and dropped without output.
// Synchronous reset clears the sequencer, the converter and the output valid.
`timescale 1ns / 1ps

module lcd_number_to_expander_bytes_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [lcdx_pkg::CMD_W-1:0]   cmd,
  input  logic [lcdx_pkg::VALUE_W-1:0] value,
  input  logic                         line,
  input  logic [lcdx_pkg::COL_W-1:0]   column,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output logic [7:0]                   expander_byte,
  output logic                         last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic                         dec_long;
  logic                         accept;
  logic                         bcd_start;
  logic                         bcd_done;
  logic [lcdx_pkg::BCD_W-1:0]   bcd;
  logic [lcdx_pkg::VALUE_W-1:0] bcd_in;
  logic                         emit_busy;
  logic                         load;
  lcdx_pkg::lcdx_load_t         load_data;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign bcd_in    = (cmd == lcdx_pkg::CMD_DEC16) ? value : {8'h00, value[7:0]};

  always_comb begin
    state_next = state;
    bcd_start  = 1'b0;
    load       = 1'b0;
    load_data  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd) inside
            lcdx_pkg::CMD_DEC8, lcdx_pkg::CMD_DEC16: begin
              bcd_start  = 1'b1;
              state_next = S_CONV;
            end
            lcdx_pkg::CMD_CHAR: begin
              load            = 1'b1;
              load_data.chars = {value[7:0], 40'h0};
              load_data.count = 3'd1;
              load_data.rs    = 1'b1;
              state_next      = S_EMIT;
            end
            lcdx_pkg::CMD_HEX8: begin
              load            = 1'b1;
              load_data.chars = {lcdx_pkg::hex_char(value[7:4]),
                                 lcdx_pkg::hex_char(value[3:0]), 32'h0};
              load_data.count = 3'd2;
              load_data.rs    = 1'b1;
              state_next      = S_EMIT;
            end
            lcdx_pkg::CMD_HEX16: begin
              load            = 1'b1;
              load_data.chars = {lcdx_pkg::CHAR_ZERO, lcdx_pkg::CHAR_X,
                                 lcdx_pkg::hex_char(value[15:12]),
                                 lcdx_pkg::hex_char(value[11:8]),
                                 lcdx_pkg::hex_char(value[7:4]),
                                 lcdx_pkg::hex_char(value[3:0])};
              load_data.count = 3'd6;
              load_data.rs    = 1'b1;
              state_next      = S_EMIT;
            end
            lcdx_pkg::CMD_CURSOR: begin
              // set DDRAM address: 0x80 + line*0x40 + column
              load            = 1'b1;
              load_data.chars = {1'b1, line, column, 40'h0};
              load_data.count = 3'd1;
              load_data.rs    = 1'b0;
              state_next      = S_EMIT;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          load         = 1'b1;
          load_data.rs = 1'b1;
          if (dec_long) begin
            load_data.chars = {lcdx_pkg::dec_char(bcd[19:16]), lcdx_pkg::dec_char(bcd[15:12]),
                               lcdx_pkg::dec_char(bcd[11:8]), lcdx_pkg::dec_char(bcd[7:4]),
                               lcdx_pkg::dec_char(bcd[3:0]), 8'h00};
            load_data.count = 3'd5;
          end else begin
            load_data.chars = {lcdx_pkg::dec_char(bcd[11:8]), lcdx_pkg::dec_char(bcd[7:4]),
                               lcdx_pkg::dec_char(bcd[3:0]), 24'h0};
            load_data.count = 3'd3;
          end
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      if (bcd_start) begin
        dec_long <= (cmd == lcdx_pkg::CMD_DEC16);
      end
    end
  end

  lcdx_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .bin_in (bcd_in),
    .done   (bcd_done),
    .bcd    (bcd)
  );

  lcdx_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .load_data     (load_data),
    .busy          (emit_busy),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .expander_byte (expander_byte),
    .last          (last)
  );

endmodule

// File: sv/lcdx_bcd.sv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
`timescale 1ns / 1ps

module lcdx_bcd (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lcdx_pkg::VALUE_W-1:0] bin_in,
  output logic                         done,
  output logic [lcdx_pkg::BCD_W-1:0]   bcd
);

  logic [lcdx_pkg::VALUE_W-1:0]  bin;
  logic [lcdx_pkg::BITCNT_W-1:0] bitcnt;
  logic                          busy;
  logic [lcdx_pkg::BCD_W-1:0]    adj;

  always_comb begin
    for (int i = 0; i < lcdx_pkg::DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        bin    <= bin_in;
        bcd    <= '0;
        bitcnt <= '1;
      end else if (busy) begin
        // adjust digits, then shift in the next binary bit
        bcd    <= {adj[lcdx_pkg::BCD_W-2:0], bin[lcdx_pkg::VALUE_W-1]};
        bin    <= {bin[lcdx_pkg::VALUE_W-2:0], 1'b0};
        bitcnt <= bitcnt - 1'b1;
        if (bitcnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/lcdx_emit.sv
// Character shifter and strobe sequencer that emits expander bytes.
`timescale 1ns / 1ps

module lcdx_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lcdx_pkg::lcdx_load_t load_data,
  output logic                 busy,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output logic [7:0]           expander_byte,
  output logic                 last
);

  logic [lcdx_pkg::CHARS_W-1:0] chars;
  logic [lcdx_pkg::COUNT_W-1:0] left;
  logic                         nib;
  logic [1:0]                   phase;
  logic                         rs;
  logic                         advance;
  logic [3:0]                   nibble;
  logic [7:0]                   ctrl;

  assign advance = busy && (!byte_valid || !byte_stall);
  assign nibble  = nib ? chars[lcdx_pkg::CHARS_W-5 -: 4] : chars[lcdx_pkg::CHARS_W-1 -: 4];

  always_comb begin
    if (phase == lcdx_pkg::PH_PULSE) begin
      ctrl = rs ? lcdx_pkg::BYTE_DATA_STROBE : lcdx_pkg::BYTE_CMD_STROBE;
    end else begin
      ctrl = rs ? lcdx_pkg::BYTE_DATA_IDLE : lcdx_pkg::BYTE_CMD_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      byte_valid <= 1'b0;
      left       <= '0;
      nib        <= 1'b0;
      phase      <= lcdx_pkg::PH_SETUP;
    end else begin
      byte_valid <= advance || (byte_valid && byte_stall);
      if (load) begin
        busy  <= 1'b1;
        chars <= load_data.chars;
        left  <= load_data.count;
        rs    <= load_data.rs;
        nib   <= 1'b0;
        phase <= lcdx_pkg::PH_SETUP;
      end else if (advance) begin
        expander_byte <= {nibble, 4'b0000} | ctrl;
        last          <= (left == 3'd1) && nib && (phase == lcdx_pkg::PH_HOLD);
        if (phase == lcdx_pkg::PH_HOLD) begin
          phase <= lcdx_pkg::PH_SETUP;
          if (nib) begin
            // drop the finished character
            nib   <= 1'b0;
            chars <= {chars[lcdx_pkg::CHARS_W-lcdx_pkg::CHAR_W-1:0],
                      {lcdx_pkg::CHAR_W{1'b0}}};
            left  <= left - 1'b1;
            if (left == 3'd1) begin
              busy <= 1'b0;
            end
          end else begin
            nib <= 1'b1;
          end
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

endmodule

// File: sv/lcdx_checker.sv
// Port-level assertions for the LCD expander encoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcdx_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_stall,
  input logic [lcdx_pkg::CMD_W-1:0]   cmd,
  input logic                         byte_valid,
  input logic                         byte_stall,
  input logic [7:0]                   expander_byte,
  input logic                         last
);

  logic       cmd_take;
  logic       cmd_known;
  logic       byte_hold;
  logic [8:0] out_word;

  assign cmd_take  = cmd_valid && !cmd_stall;
  // codes above the cursor move are dropped without output
  assign cmd_known = (cmd <= lcdx_pkg::CMD_CURSOR);
  assign byte_hold = byte_valid && byte_stall;
  assign out_word  = {expander_byte, last};

  `LCDX_ASSERT(a_out_hold, byte_hold |=> byte_valid && $stable(out_word), "stalled item changed")
  `LCDX_ASSERT(a_busy_after_cmd, cmd_take && cmd_known |=> cmd_stall, "no stall after a command")
  `LCDX_ASSERT(a_idle_only_last, !cmd_stall && byte_valid |-> last, "ready before sequence end")
  `LCDX_ASSERT(a_backlight, byte_valid |-> expander_byte[3] && !expander_byte[1], "control bits wrong")
  `LCDX_ASSERT_ALWAYS(a_reset_clear, rst |=> !byte_valid && !cmd_stall, "reset left the block busy")

endmodule

bind lcd_number_to_expander_bytes_top lcdx_checker u_checker (.*);

// File: tb/lcd_number_to_expander_bytes_checker.sv
// Checker: predicts the expander byte stream for each command and compares it with the output.
`timescale 1ns / 1ps

module lcd_number_to_expander_bytes_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic [lcdx_pkg::CMD_W-1:0]   cmd,
  input  logic [lcdx_pkg::VALUE_W-1:0] value,
  input  logic                         line,
  input  logic [lcdx_pkg::COL_W-1:0]   column,
  input  logic                         byte_valid,
  input  logic                         byte_stall,
  input  logic [7:0]                   expander_byte,
  input  logic                         last,
  output int                           fail_count,
  output int                           pending
);

  import lcdx_pkg::*;

  typedef struct packed {
    logic [7:0] wr;
    logic       last;
  } lcd_write_t;

  lcd_write_t expected_writes[$];
  lcd_write_t oldest_write;
  int         mismatches;

  // One nibble is three expander writes: enable low, high, low.
  function automatic void queue_nibble(input logic [3:0] nib, input logic rs);
    logic [7:0] idle;
    logic [7:0] strobe;
    lcd_write_t w;
    idle   = rs ? BYTE_DATA_IDLE : BYTE_CMD_IDLE;
    strobe = rs ? BYTE_DATA_STROBE : BYTE_CMD_STROBE;
    w.last = 1'b0;
    w.wr = {nib, idle[3:0]};
    expected_writes.push_back(w);
    w.wr = {nib, strobe[3:0]};
    expected_writes.push_back(w);
    w.wr = {nib, idle[3:0]};
    expected_writes.push_back(w);
  endfunction

  function automatic void queue_lcd_byte(input logic [7:0] b, input logic rs);
    queue_nibble(b[7:4], rs);
    queue_nibble(b[3:0], rs);
  endfunction

  function automatic logic [7:0] ascii_hex(input logic [3:0] d);
    return (d > 4'd9) ? ({4'h0, d} + 8'h37) : ({4'h0, d} + 8'h30);
  endfunction

  function automatic logic [7:0] ascii_dec(input int unsigned n);
    return 8'h30 + 8'(n % 10);
  endfunction

  function automatic void encode_command(input logic [CMD_W-1:0] c,
                                         input logic [VALUE_W-1:0] v,
                                         input logic l,
                                         input logic [COL_W-1:0] col);
    logic [7:0]  low8;
    int unsigned num;
    int unsigned div;
    low8 = v[7:0];
    case (c)
      CMD_CHAR: begin
        queue_lcd_byte(low8, 1'b1);
      end
      CMD_HEX8: begin
        queue_lcd_byte(ascii_hex(low8[7:4]), 1'b1);
        queue_lcd_byte(ascii_hex(low8[3:0]), 1'b1);
      end
      CMD_HEX16: begin
        queue_lcd_byte(8'h30, 1'b1);
        queue_lcd_byte(8'h78, 1'b1);
        queue_lcd_byte(ascii_hex(v[15:12]), 1'b1);
        queue_lcd_byte(ascii_hex(v[11:8]), 1'b1);
        queue_lcd_byte(ascii_hex(v[7:4]), 1'b1);
        queue_lcd_byte(ascii_hex(v[3:0]), 1'b1);
      end
      CMD_DEC8: begin
        num = low8;
        queue_lcd_byte(ascii_dec(num / 100), 1'b1);
        queue_lcd_byte(ascii_dec(num / 10), 1'b1);
        queue_lcd_byte(ascii_dec(num), 1'b1);
      end
      CMD_DEC16: begin
        num = v;
        div = 10000;
        for (int i = 0; i < 5; i++) begin
          queue_lcd_byte(ascii_dec(num / div), 1'b1);
          div = div / 10;
        end
      end
      CMD_CURSOR: begin
        queue_lcd_byte(8'h80 + (l ? 8'h40 : 8'h00) + {2'b00, col}, 1'b0);
      end
      default: begin
        // unused codes give nothing
        return;
      end
    endcase
    expected_writes[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_writes.delete();
      mismatches = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        encode_command(cmd, value, line, column);
      end
      if (byte_valid && !byte_stall) begin
        if (expected_writes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item expander_byte %02h last %0b",
                   $time, expander_byte, last);
        end else begin
          oldest_write = expected_writes.pop_front();
          if (oldest_write.wr !== expander_byte) begin
            mismatches++;
            $display("%0t: expander_byte expected %02h actual %02h",
                     $time, oldest_write.wr, expander_byte);
          end
          if (oldest_write.last !== last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b",
                     $time, oldest_write.last, last);
          end
        end
      end
    end
    // publish after the edge so the top reads settled values
    pending    <= expected_writes.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/lcd_number_to_expander_bytes_top_tb.sv
// Testbench top: drives commands and byte-side stalls, and reports the verdict.
`timescale 1ns / 1ps

module lcd_number_to_expander_bytes_top_tb;

  import lcdx_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 76;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [CMD_W-1:0]   cmd = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               line = 1'b0;
  logic [COL_W-1:0]   column = '0;
  logic               byte_valid;
  logic               byte_stall = 1'b0;
  logic [7:0]         expander_byte;
  logic               last;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_request = 1'b0;

  lcd_number_to_expander_bytes_top dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd(cmd), .value(value), .line(line), .column(column),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .expander_byte(expander_byte), .last(last)
  );

  lcd_number_to_expander_bytes_checker checker_i (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd(cmd), .value(value), .line(line), .column(column),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .expander_byte(expander_byte), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one command after a random gap and hold it until accepted.
  task automatic offer_command(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                               input logic l, input logic [COL_W-1:0] col);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    value     <= v;
    line      <= l;
    column    <= col;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Receiver: random stall before each item, with a single long hold-off on request.
  initial begin
    int wait_n;
    int taken;
    taken = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        byte_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (taken % 30 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      wait_n = recv_burst ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        byte_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      byte_stall <= 1'b0;
      @(posedge clk);
      while (!byte_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: count cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (byte_valid && !byte_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lcd_number_to_expander_bytes_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int useful;
    int pick;
    logic [CMD_W-1:0]   c;
    logic [VALUE_W-1:0] v;
    useful = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, wide values on 8-bit commands, unused codes
    offer_command(CMD_CHAR,   16'h0000, 1'b0, 6'd0);
    offer_command(CMD_CHAR,   16'h00FF, 1'b1, 6'd63);
    offer_command(CMD_CHAR,   16'hAB41, 1'b0, 6'd21);
    offer_command(CMD_HEX8,   16'h0000, 1'b1, 6'd0);
    offer_command(CMD_HEX8,   16'h00FF, 1'b0, 6'd63);
    offer_command(CMD_HEX8,   16'h129E, 1'b1, 6'd42);
    offer_command(CMD_HEX16,  16'h0000, 1'b0, 6'd1);
    offer_command(CMD_HEX16,  16'hFFFF, 1'b1, 6'd2);
    offer_command(CMD_HEX16,  16'hA5C3, 1'b0, 6'd3);
    offer_command(CMD_DEC8,   16'h0000, 1'b1, 6'd4);
    offer_command(CMD_DEC8,   16'h00FF, 1'b0, 6'd5);
    offer_command(CMD_DEC8,   16'hFF09, 1'b1, 6'd6);
    offer_command(CMD_DEC16,  16'd0,    1'b0, 6'd7);
    offer_command(CMD_DEC16,  16'd65535, 1'b1, 6'd8);
    offer_command(CMD_DEC16,  16'd10000, 1'b0, 6'd9);
    offer_command(CMD_DEC16,  16'd9999, 1'b1, 6'd10);
    offer_command(CMD_CURSOR, 16'h0000, 1'b0, 6'd0);
    offer_command(CMD_CURSOR, 16'hFFFF, 1'b1, 6'd63);
    offer_command(CMD_CURSOR, 16'h1234, 1'b0, 6'd63);
    offer_command(CMD_CURSOR, 16'h0000, 1'b1, 6'd0);
    offer_command(CMD_SPARE_A, 16'hFFFF, 1'b1, 6'd63);
    offer_command(CMD_CHAR,   16'h0055, 1'b0, 6'd0);
    offer_command(CMD_SPARE_B, 16'h0000, 1'b0, 6'd0);
    offer_command(CMD_HEX8,   16'h005A, 1'b1, 6'd33);

    while (useful < RANDOM_ITEMS) begin
      if (useful % 16 == 0) send_burst = ($urandom_range(0, 2) == 0);
      // hold off the receiver while the sender keeps pushing back-to-back
      if (useful == 50) begin
        send_burst = 1'b1;
        hold_request = 1'b1;
      end
      pick = $urandom_range(0, 19);
      c = (pick == 19) ? ($urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A)
                       : CMD_W'(pick % 6);
      case ($urandom_range(0, 5))
        0:       v = 16'h0000;
        1:       v = 16'hFFFF;
        2:       v = VALUE_W'($urandom_range(0, 255));
        default: v = VALUE_W'($urandom);
      endcase
      offer_command(c, v, 1'($urandom_range(0, 1)), COL_W'($urandom_range(0, 63)));
      if (c != CMD_SPARE_A && c != CMD_SPARE_B) useful++;
    end
    cmd_valid <= 1'b0;

    // let the checker see the last accept, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("lcd_number_to_expander_bytes_top_tb: PASS");
    end else begin
      $display("lcd_number_to_expander_bytes_top_tb: FAIL");
    end
    $finish;
  end

endmodule
